// ----- rtl/core/sui_pkg.sv -----
// Shared constants, types and result codes for the sorted unique insert table.
package sui_pkg;

  // Table geometry
  localparam int unsigned Capacity  = 16;
  localparam int unsigned ValueBits = 31;
  localparam int unsigned IdxBits   = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntBits   = $clog2(Capacity + 1);

  // Fixed port field widths
  localparam int unsigned InBits       = 31;
  localparam int unsigned StatusBits   = 2;
  localparam int unsigned PositionBits = 4;
  localparam int unsigned TotalBits    = 5;

  // Result status codes
  typedef enum logic [StatusBits-1:0] {
    StInserted  = 2'd0,
    StDuplicate = 2'd1,
    StFull      = 2'd2
  } sui_status_e;

  // Per-cell compare flags handed to the row logic
  typedef struct packed {
    logic lt;    // held entry is below the probe value
    logic eq;    // held entry equals the probe value
    logic slot;  // first cell whose entry is not below the probe value
  } sui_cmp_t;

endpackage

// ----- rtl/core/sorted_unique_insert_table.sv -----
// Results: each result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless the output stalls; the compare row and the count
// update at the same edge, so the next beat sees the updated table, and an output
// register parts both sides. Reset: entry count and output valid clear asynchronously;
// cell entries are not reset and are only read below the entry count.
module sorted_unique_insert_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sui_pkg::InBits-1:0]       new_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sui_pkg::StatusBits-1:0]   status_o,
  output logic [sui_pkg::PositionBits-1:0] position_o,
  output logic [sui_pkg::TotalBits-1:0]    entry_total_o
);
  import sui_pkg::*;

  logic [ValueBits-1:0] value;
  logic [ValueBits-1:0] entry     [Capacity];
  sui_cmp_t             cmp       [Capacity];
  logic [Capacity-1:0]  eq_hot;
  logic [Capacity-1:0]  slot_hot;
  logic [IdxBits-1:0]   eq_idx;
  logic [IdxBits-1:0]   slot_idx;

  logic                 accept;
  logic                 found;
  logic                 full;
  logic                 insert;

  logic [CntBits-1:0]   count_d, count_q;
  logic                 out_valid_d, out_valid_q;
  sui_status_e          status_d, status_q;
  logic [IdxBits-1:0]   position_d, position_q;
  logic [CntBits-1:0]   total_d, total_q;

  assign value      = ValueBits'(new_value_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Build the row of cells; each hands its entry and compare flag to the next
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [ValueBits-1:0] left_entry;
    logic                 left_lt;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_lt    = 1'b1;
    end else begin : g_rest
      assign left_entry = entry[i-1];
      assign left_lt    = cmp[i-1].lt;
    end

    sui_cell u_cell (
      .clk_i       (clk_i),
      .value_i     (value),
      .left_entry_i(left_entry),
      .left_lt_i   (left_lt),
      .occupied_i  (CntBits'(i) < count_q),
      .insert_i    (insert),
      .entry_o     (entry[i]),
      .cmp_o       (cmp[i])
    );

    assign eq_hot[i]   = cmp[i].eq;
    assign slot_hot[i] = cmp[i].slot;
  end

  // Encode the duplicate index and the insert slot
  sui_encode u_eq_enc (
    .hot_i(eq_hot),
    .idx_o(eq_idx)
  );

  sui_encode u_slot_enc (
    .hot_i(slot_hot),
    .idx_o(slot_idx)
  );

  assign found  = |eq_hot;
  assign full   = (count_q == CntBits'(Capacity));
  assign insert = accept && !found && !full;

  // Decide the result and the next count
  always_comb begin
    count_d    = count_q;
    status_d   = status_q;
    position_d = position_q;
    total_d    = total_q;
    if (accept) begin
      if (found) begin
        status_d   = StDuplicate;
        position_d = eq_idx;
        total_d    = count_q;
      end else if (full) begin
        status_d   = StFull;
        position_d = '0;
        total_d    = count_q;
      end else begin
        status_d   = StInserted;
        position_d = slot_idx;
        count_d    = count_q + CntBits'(1);
        total_d    = count_q + CntBits'(1);
      end
    end
  end

  // Hold the result while stalled, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    position_q <= position_d;
    total_q    <= total_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = StatusBits'(status_q);
  assign position_o    = PositionBits'(position_q);
  assign entry_total_o = TotalBits'(total_q);

endmodule

// ----- rtl/core/sui_cell.sv -----
// One table cell: holds an entry, compares it with the probe and shifts on insert.
module sui_cell (
  input  logic                       clk_i,
  input  logic [sui_pkg::ValueBits-1:0] value_i,
  input  logic [sui_pkg::ValueBits-1:0] left_entry_i,
  input  logic                       left_lt_i,
  input  logic                       occupied_i,
  input  logic                       insert_i,
  output logic [sui_pkg::ValueBits-1:0] entry_o,
  output sui_pkg::sui_cmp_t          cmp_o
);
  import sui_pkg::*;

  logic [ValueBits-1:0] entry_d, entry_q;

  // Compare the held entry with the probe value
  always_comb begin
    cmp_o.lt   = occupied_i && (entry_q < value_i);
    cmp_o.eq   = occupied_i && (entry_q == value_i);
    cmp_o.slot = left_lt_i && !cmp_o.lt;
  end

  // Take the left neighbor above the slot, the new value at the slot, hold below
  always_comb begin
    entry_d = entry_q;
    if (insert_i) begin
      if (!left_lt_i) begin
        entry_d = left_entry_i;
      end else if (!cmp_o.lt) begin
        entry_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/core/sui_encode.sv -----
// One-hot to binary index encoder across the cell row.
module sui_encode (
  input  logic [sui_pkg::Capacity-1:0] hot_i,
  output logic [sui_pkg::IdxBits-1:0]  idx_o
);
  import sui_pkg::*;

  // OR together the index of every set bit; at most one is set
  always_comb begin
    idx_o = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      if (hot_i[i]) begin
        idx_o = idx_o | IdxBits'(i);
      end
    end
  end

endmodule

// ----- rtl/core/sui_checker.sv -----
// Port-level checker for the sorted unique insert table, bound to the top level.
module sui_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [sui_pkg::StatusBits-1:0]   status_o,
  input logic [sui_pkg::PositionBits-1:0] position_o,
  input logic [sui_pkg::TotalBits-1:0]    entry_total_o
);
  import sui_pkg::*;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(position_o) && $stable(entry_total_o))
    else $error("stalled result beat changed");

  // Every accepted input beat yields a result beat in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StInserted) || (status_o == StDuplicate)
      || (status_o == StFull))
    else $error("undefined status code");

  // A full rejection reports position zero and a full table
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StFull) |->
      (position_o == '0) && (entry_total_o == TotalBits'(Capacity)))
    else $error("full rejection with wrong position or total");

  // An insert lands below the new entry total
  a_insert_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StInserted) |->
      (TotalBits'(position_o) < entry_total_o) && (entry_total_o != '0))
    else $error("insert position beyond entry total");

endmodule

bind sorted_unique_insert_table sui_checker u_sui_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .position_o   (position_o),
  .entry_total_o(entry_total_o)
);

// ----- test/testbench.sv -----
// Testbench for the sorted unique insert table: queued stimulus, scoreboard and watchdog.
`timescale 1ns / 100ps

module testbench;
  import sui_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int RandomBeats = 1600;
  localparam int HoldCycles  = 80;
  localparam int HoldAfter   = 400;

  // One predicted outcome per accepted beat
  typedef struct {
    sui_status_e              status;
    logic [PositionBits-1:0]  position;
    logic [TotalBits-1:0]     total;
  } table_reply_t;

  logic                    clk_i     = 1'b0;
  logic                    rst_ni    = 1'b0;
  logic                    in_valid  = 1'b0;
  logic [InBits-1:0]       new_value = '0;
  logic                    out_stall = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic [StatusBits-1:0]   status_o;
  logic [PositionBits-1:0] position_o;
  logic [TotalBits-1:0]    entry_total_o;

  logic [InBits-1:0]       pending_values[$];
  table_reply_t            reply_q[$];
  logic [ValueBits-1:0]    held_entries[Capacity];
  int                      held_count   = 0;
  int                      beats_taken  = 0;
  int                      replies_seen = 0;
  int                      fail_count   = 0;
  logic                    steady;

  sorted_unique_insert_table u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .new_value_i  (new_value),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .status_o     (status_o),
    .position_o   (position_o),
    .entry_total_o(entry_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Turn off idling on both sides for a stretch in the middle of the run
  assign steady = (beats_taken >= 900) && (beats_taken < 1200);

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // Search the held entries, then insert in order unless duplicate or full
  task automatic predict_insert(input logic [InBits-1:0] raw);
    logic [ValueBits-1:0] probe;
    int                   hit;
    int                   slot;
    table_reply_t         reply;
    probe = raw[ValueBits-1:0];
    hit   = -1;
    for (int i = 0; i < held_count; i++) begin
      if (hit < 0 && held_entries[i] == probe) hit = i;
    end
    if (hit >= 0) begin
      reply.status   = StDuplicate;
      reply.position = hit[PositionBits-1:0];
    end else if (held_count >= Capacity) begin
      reply.status   = StFull;
      reply.position = '0;
    end else begin
      slot = 0;
      while (slot < held_count && held_entries[slot] < probe) slot++;
      for (int i = held_count; i > slot; i--) held_entries[i] = held_entries[i-1];
      held_entries[slot] = probe;
      held_count++;
      reply.status   = StInserted;
      reply.position = slot[PositionBits-1:0];
    end
    reply.total = held_count[TotalBits-1:0];
    reply_q.push_back(reply);
  endtask

  // Present queued beats, predicting each one as it is accepted
  always @(posedge clk_i) begin : drive_beats
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_insert(new_value);
        beats_taken++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_values.size() > 0 && (steady || $urandom_range(99) >= 34)) begin
          in_valid  <= 1'b1;
          new_value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check result beats against the oldest prediction and drive the stall
  always @(posedge clk_i) begin : check_results
    table_reply_t want;
    int           hold_left;
    bit           hold_done;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending, status %0d", status_o));
        end else begin
          want = reply_q.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
          if (position_o !== want.position)
            report_mismatch($sformatf("position got %0d want %0d", position_o, want.position));
          if (entry_total_o !== want.total)
            report_mismatch($sformatf("entry_total got %0d want %0d", entry_total_o,
                                      want.total));
        end
      end
      // Hold off once for a long stretch so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && replies_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 34);
      end
    end
  end

  // End the run when nothing moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [InBits-1:0] planted[$];
    logic [InBits-1:0] fill[$];
    int                pick;

    fill = '{31'h0000_0001, 31'h4000_0000, 31'h2AAA_AAAA, 31'h5555_5555, 31'd2000,
             31'd999, 31'd1001, 31'h3FFF_FFFF, 31'd7, 31'h7FFF_FFFE, 31'd12345,
             31'h1234_5678};

    // Empty table, duplicate, then the extremes of the value range
    pending_values.push_back(31'd1000);
    pending_values.push_back(31'd1000);
    pending_values.push_back(31'h0000_0000);
    pending_values.push_back(31'h7FFF_FFFF);
    pending_values.push_back(31'd500);
    pending_values.push_back(31'h7FFF_FFFF);
    planted = '{31'd1000, 31'h0000_0000, 31'h7FFF_FFFF, 31'd500};
    // Fill up to capacity at scattered positions
    foreach (fill[i]) begin
      pending_values.push_back(fill[i]);
      planted.push_back(fill[i]);
    end
    // Full table: fresh value rejected, duplicates at both ends still found
    pending_values.push_back(31'd3);
    pending_values.push_back(31'h0000_0000);
    pending_values.push_back(31'h7FFF_FFFF);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pause the sender until every predicted result has drained
    while (pending_values.size() > 0 || in_valid || reply_q.size() > 0) @(posedge clk_i);

    // Random beats: held values, small values and full-width values
    for (int n = 0; n < RandomBeats; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) pending_values.push_back(planted[$urandom_range(planted.size() - 1)]);
      else if (pick < 55) pending_values.push_back(InBits'($urandom_range(40)));
      else pending_values.push_back(InBits'($urandom));
    end

    while (pending_values.size() > 0 || in_valid || reply_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (reply_q.size() > 0) report_mismatch($sformatf("%0d results never arrived", reply_q.size()));

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
